// ----- rtl/core/stable_sorted_priority_queue_top_assert.svh -----
// Assertion macros shared by the queue RTL.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SSPQ_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Property where the consequent must hold at the clock after the antecedent.
`define SSPQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sspq_pkg.sv -----
package sspq_pkg;

  localparam int CMD_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_DEQUEUE = 2'd1;

  // Broadcast from the top level to every cell for the current item.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/sspq_cell.sv -----
module sspq_cell #(
  parameter int PRIO_BITS    = 16,
  parameter int PAYLOAD_BITS = 16,
  parameter int CNT_BITS     = 5,
  parameter int CELL_IDX     = 0
) (
  input  logic                    clk,
  input  sspq_pkg::cell_ctrl_t    ctrl,
  input  logic [CNT_BITS-1:0]     count,
  input  logic [PRIO_BITS-1:0]    new_prio,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic                    left_ins,
  input  logic [PRIO_BITS-1:0]    left_prio,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [PRIO_BITS-1:0]    right_prio,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic                    ins,
  output logic [PRIO_BITS-1:0]    prio,
  output logic [PAYLOAD_BITS-1:0] payload
);
  import sspq_pkg::*;

  logic occupied;
  logic at_tail;

  // The slot is held when its index lies below the count; the first free
  // slot always takes part in an insert.
  assign occupied = CNT_BITS'(CELL_IDX) < count;
  assign at_tail  = CNT_BITS'(CELL_IDX) == count;

  // A new entry goes after every equal priority, so only a strictly larger
  // held priority gives way.
  assign ins = (occupied && (prio > new_prio)) || at_tail;

  always_ff @(posedge clk) begin
    if (ctrl.enq && ins) begin
      if (left_ins) begin
        prio    <= left_prio;
        payload <= left_payload;
      end else begin
        prio    <= new_prio;
        payload <= new_payload;
      end
    end else if (ctrl.deq) begin
      prio    <= right_prio;
      payload <= right_payload;
    end
  end

endmodule

// ----- rtl/core/stable_sorted_priority_queue_top.sv -----
// Stable minimum priority queue built as a row of DEPTH cells kept in
// ascending priority order; cell 0 holds the head.
// Command channel (cmd_valid, cmd_stall): command 0 enqueues entry_payload
// with entry_priority, 1 removes the head, 2 or 3 only reports status.
// An item is accepted at a clock edge with cmd_valid high and cmd_stall low.
// Response channel (rsp_valid, rsp_stall): every accepted item gives exactly
// one response carrying the dequeued entry (out_valid), the refused flag for
// an enqueue into a full store, and the count, empty flag and head priority
// after the step; head_priority is -1 when the store is empty.
// The response is registered at the edge that accepts the item. Throughput
// is one item per cycle while the receiver does not stall, since every cell
// compares its priority with the new one and shifts left or right at that edge.
// When the receiver stalls, the response register holds its item and
// cmd_stall rises, so no further item is taken until the response leaves.
// Reset clears the count and the response valid; the cell contents need no
// reset because only slots below the count are ever read.
`include "stable_sorted_priority_queue_top_assert.svh"

module stable_sorted_priority_queue_top #(
  parameter int DEPTH        = 16,
  parameter int PRIO_BITS    = 16,
  parameter int PAYLOAD_BITS = 16,
  localparam int CNT_BITS    = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [sspq_pkg::CMD_BITS-1:0]  command,
  input  logic [PAYLOAD_BITS-1:0]        entry_payload,
  input  logic [PRIO_BITS-1:0]           entry_priority,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           out_valid,
  output logic [PAYLOAD_BITS-1:0]        out_payload,
  output logic [PRIO_BITS-1:0]           out_priority,
  output logic                           refused,
  output logic [CNT_BITS-1:0]            entry_count,
  output logic                           is_empty,
  output logic signed [PRIO_BITS:0]      head_priority
);
  import sspq_pkg::*;

  logic [CNT_BITS-1:0]     count;
  logic [CNT_BITS-1:0]     count_next;
  logic                    accept;
  logic                    is_enq;
  logic                    is_deq;
  logic                    full;
  logic                    do_enq;
  logic                    do_deq;
  logic [PRIO_BITS:0]      head_next;
  cell_ctrl_t              ctrl;

  logic [PRIO_BITS-1:0]    cell_prio    [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
  logic                    cell_ins     [DEPTH];

  // The response register frees the command side unless it is blocked.
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign is_enq = command == CMD_ENQUEUE;
  assign is_deq = command == CMD_DEQUEUE;
  assign full   = count == CNT_BITS'(DEPTH);
  assign do_enq = accept && is_enq && !full;
  assign do_deq = accept && is_deq && (count != '0);

  assign ctrl.enq = do_enq;
  assign ctrl.deq = do_deq;

  always_comb begin
    priority if (do_enq) begin
      count_next = count + CNT_BITS'(1);
    end else if (do_deq) begin
      count_next = count - CNT_BITS'(1);
    end else begin
      count_next = count;
    end
  end

  // Head after the step: an insert lands at the head when cell 0 gives way,
  // a removal brings up cell 1.
  always_comb begin
    priority if (count_next == '0) begin
      head_next = '1;
    end else if (do_enq && cell_ins[0]) begin
      head_next = {1'b0, entry_priority};
    end else if (do_deq) begin
      head_next = {1'b0, cell_prio[1]};
    end else begin
      head_next = {1'b0, cell_prio[0]};
    end
  end

  // Row of cells: each cell shifts toward the tail on an insert in front of
  // it and toward the head on a removal.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_ins;
    logic [PRIO_BITS-1:0]    left_prio;
    logic [PAYLOAD_BITS-1:0] left_payload;
    logic [PRIO_BITS-1:0]    right_prio;
    logic [PAYLOAD_BITS-1:0] right_payload;

    if (i == 0) begin : g_head
      assign left_ins     = 1'b0;
      assign left_prio    = entry_priority;
      assign left_payload = entry_payload;
    end else begin : g_mid
      assign left_ins     = cell_ins[i-1];
      assign left_prio    = cell_prio[i-1];
      assign left_payload = cell_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio    = cell_prio[i];
      assign right_payload = cell_payload[i];
    end else begin : g_body
      assign right_prio    = cell_prio[i+1];
      assign right_payload = cell_payload[i+1];
    end

    sspq_cell #(
      .PRIO_BITS    (PRIO_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CNT_BITS     (CNT_BITS),
      .CELL_IDX     (i)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .count         (count),
      .new_prio      (entry_priority),
      .new_payload   (entry_payload),
      .left_ins      (left_ins),
      .left_prio     (left_prio),
      .left_payload  (left_payload),
      .right_prio    (right_prio),
      .right_payload (right_payload),
      .ins           (cell_ins[i]),
      .prio          (cell_prio[i]),
      .payload       (cell_payload[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response fields are captured with the item and held while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid     <= do_deq;
      out_payload   <= do_deq ? cell_payload[0] : '0;
      out_priority  <= do_deq ? cell_prio[0] : '0;
      refused       <= is_enq && full;
      entry_count   <= count_next;
      is_empty      <= count_next == '0;
      head_priority <= head_next;
    end
  end

  `SSPQ_ASSERT_ALWAYS(a_count_bound, count <= CNT_BITS'(DEPTH), "count exceeds depth")

  `SSPQ_ASSERT_NEXT(a_refuse_full, accept && is_enq && full,
                    rsp_valid && refused && (entry_count == CNT_BITS'(DEPTH)),
                    "refused enqueue not reported as full")

  `SSPQ_ASSERT_NEXT(a_deq_count, do_deq,
                    out_valid && (count == $past(count) - CNT_BITS'(1)),
                    "dequeue did not return an entry and shrink the count")

  `SSPQ_ASSERT_ALWAYS(a_empty_flag, !rsp_valid || (is_empty == (entry_count == '0)),
                      "empty flag disagrees with count")

endmodule
